/* src/epid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enhanced PID package
// Shared types, register indexes, mode bits and saturating helpers for the
// Q16.32 positional PID controller.
// ----------------------------------------------------------------------------
package epid_pkg;

    typedef logic signed [47:0] q48_t;

    typedef enum logic [1:0] {
        ALU_MUL = 2'b01,
        ALU_DIV = 2'b10
    } alu_op_t;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        logic [47:0] a;
        logic [47:0] b;
    } alu_req_t;

    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_OUT_LIMIT = 3'd3;
    localparam logic [2:0] REG_INT_CLAMP = 3'd4;
    localparam logic [2:0] REG_DEAD_BAND = 3'd5;
    localparam logic [2:0] REG_MODE      = 3'd6;
    localparam logic [2:0] REG_DFILT_RC  = 3'd7;

    localparam int MODE_STALL  = 0;
    localparam int MODE_TRAP   = 1;
    localparam int MODE_VAR    = 2;
    localparam int MODE_DMEAS  = 3;
    localparam int MODE_DFILT  = 4;
    localparam int MODE_ICLAMP = 5;
    localparam int MODE_OFILT  = 6;

    localparam logic [47:0] OUT_FRAC_Q  = 48'd4294967;
    localparam logic [47:0] REF_MIN_Q   = 48'd429497;
    localparam logic [9:0]  STALL_LIMIT = 10'd500;
    localparam logic [9:0]  STALL_MAX   = 10'd1023;

    localparam q48_t Q_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam q48_t Q_MIN = 48'sh8000_0000_0000;

    function automatic logic signed [49:0] sx50(input q48_t x);
        sx50 = $signed({{2{x[47]}}, x});
    endfunction

    function automatic q48_t sat50(input logic signed [49:0] v);
        if (v > $signed({2'b00, Q_MAX}))
        begin
            sat50 = Q_MAX;
        end
        else if (v < $signed({2'b11, Q_MIN}))
        begin
            sat50 = Q_MIN;
        end
        else
        begin
            sat50 = v[47:0];
        end
    endfunction

    function automatic logic [47:0] abs48(input q48_t x);
        abs48 = x[47] ? 48'(-x) : x;
    endfunction

    function automatic logic same_sign(input q48_t a, input q48_t b);
        same_sign = (a > 48'sd0 && b > 48'sd0) || (a < 48'sd0 && b < 48'sd0);
    endfunction

endpackage

/* src/enhanced_pid_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enhanced PID controller unit
// Positional PID step in signed Q16.32 with anti-windup, optional filters
// and stall detection, sequenced over one shared multiply/divide unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input request (in_valid/in_ready) carries measure, setpoint and step_time.
//   Output request (out_valid/out_ready) carries drive, drive_sum and stalled.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle;
//   the user is bound to this, as the block itself does not enforce it.
//   One request is processed at a time; in_ready is high only when idle.
//   With every mode on, a step issues up to 10 multiplies and 6 divides
//   on the shared unit.
//   A finished result sits in the output register; the next request is
//   accepted meanwhile, and a second result waits until the first is taken.
//   Reset clears all gains, limits, mode bits and controller history.
// ----------------------------------------------------------------------------
module enhanced_pid_controller_unit #(
    parameter logic [46:0] VAR_RATE_SLOPE = 47'd4294967296,
    parameter logic [46:0] VAR_RATE_FULL  = 47'd429496730,
    parameter logic [46:0] OUT_FILTER_RC  = 47'd214748365
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [2:0]     cfg_index,
    input  logic [47:0]    cfg_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  epid_pkg::q48_t measure,
    input  epid_pkg::q48_t setpoint,
    input  logic [31:0]    step_time,
    output logic           out_valid,
    input  logic           out_ready,
    output epid_pkg::q48_t drive,
    output epid_pkg::q48_t drive_sum,
    output logic           stalled
);
    import epid_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE      = 22'b0000000000000000000001,
        S_STALL_MUL = 22'b0000000000000000000010,
        S_STALL_UPD = 22'b0000000000000000000100,
        S_ERR       = 22'b0000000000000000001000,
        S_P         = 22'b0000000000000000010000,
        S_I1        = 22'b0000000000000000100000,
        S_I2        = 22'b0000000000000001000000,
        S_D1        = 22'b0000000000000010000000,
        S_D2        = 22'b0000000000000100000000,
        S_VR        = 22'b0000000000001000000000,
        S_VR_DIV    = 22'b0000000000010000000000,
        S_VR_MUL    = 22'b0000000000100000000000,
        S_LP        = 22'b0000000001000000000000,
        S_LP_M1     = 22'b0000000010000000000000,
        S_LP_D1     = 22'b0000000100000000000000,
        S_LP_M2     = 22'b0000001000000000000000,
        S_LP_D2     = 22'b0000010000000000000000,
        S_ICLAMP    = 22'b0000100000000000000000,
        S_SUM       = 22'b0001000000000000000000,
        S_DRV       = 22'b0010000000000000000000,
        S_OCLAMP    = 22'b0100000000000000000000,
        S_FIN       = 22'b1000000000000000000000
    } state_t;

    state_t      state_reg;

    q48_t        gain_p_reg;
    q48_t        gain_i_reg;
    q48_t        gain_d_reg;
    logic [46:0] out_limit_reg;
    logic [46:0] int_clamp_reg;
    logic [46:0] dead_band_reg;
    logic [6:0]  mode_reg;
    logic [46:0] dfilt_rc_reg;

    q48_t        meas_reg;
    q48_t        ref_reg;
    logic [31:0] dt_reg;
    q48_t        err_reg;
    q48_t        pout_reg;
    q48_t        iterm_reg;
    q48_t        dout_reg;
    q48_t        drv_reg;
    q48_t        tmp_reg;
    q48_t        lpa_reg;
    logic        lp_sel_reg;
    logic [47:0] thr_reg;
    logic        pend_reg;

    q48_t        prev_measure_reg;
    q48_t        prev_setpoint_reg;
    q48_t        prev_error_reg;
    q48_t        prev_deriv_reg;
    q48_t        prev_drive_reg;
    q48_t        iacc_reg;
    q48_t        run_sum_reg;
    logic [9:0]  stall_cnt_reg;
    logic        stall_flag_reg;

    logic        out_valid_reg;
    q48_t        out_drive_reg;
    q48_t        out_sum_reg;
    logic        out_stall_reg;

    alu_req_t    alu_req;
    logic        alu_done;
    q48_t        alu_res;
    logic        is_call;

    q48_t        err_c;
    logic [47:0] err_abs;
    logic signed [48:0] esum;
    logic signed [48:0] esum_adj;
    q48_t        ie;
    q48_t        dsrc;
    logic [47:0] dt48;
    logic [47:0] ae;
    logic [47:0] vr_top;
    logic [47:0] vr_num;
    logic [46:0] lp_rc;
    logic [47:0] lp_den;
    q48_t        lp_x;
    q48_t        lp_last;
    q48_t        lp_out;
    logic [47:0] pr;
    logic [48:0] sdiff;
    logic [48:0] emag;
    logic [53:0] e20;
    logic [53:0] pr19;
    logic        stall_skip;
    logic [9:0]  stall_cnt_next;
    q48_t        ti;
    q48_t        pi;
    q48_t        to;
    q48_t        clamp_s;
    q48_t        lim_s;
    q48_t        iacc_next;
    q48_t        drv_next;

    assign err_c    = sat50(sx50(ref_reg) - sx50(meas_reg));
    assign err_abs  = abs48(err_c);
    assign esum     = $signed({err_reg[47], err_reg}) + $signed({prev_error_reg[47], prev_error_reg});
    assign esum_adj = esum + $signed({48'd0, esum[48]});
    assign ie       = mode_reg[MODE_TRAP] ? esum_adj[48:1] : err_reg;
    assign dsrc     = mode_reg[MODE_DMEAS] ? sat50(sx50(prev_measure_reg) - sx50(meas_reg))
                                           : sat50(sx50(err_reg) - sx50(prev_error_reg));
    assign dt48     = {16'd0, dt_reg};
    assign ae       = abs48(err_reg);
    assign vr_top   = {1'b0, VAR_RATE_SLOPE} + {1'b0, VAR_RATE_FULL};
    assign vr_num   = vr_top - ae;
    assign lp_rc    = lp_sel_reg ? OUT_FILTER_RC : dfilt_rc_reg;
    assign lp_den   = {1'b0, lp_rc} + dt48;
    assign lp_x     = lp_sel_reg ? drv_reg : dout_reg;
    assign lp_last  = lp_sel_reg ? prev_drive_reg : prev_deriv_reg;
    assign lp_out   = sat50(sx50(lpa_reg) + sx50(alu_res));

    assign pr         = abs48(prev_setpoint_reg);
    assign sdiff      = {prev_setpoint_reg[47], prev_setpoint_reg}
                      - {prev_measure_reg[47], prev_measure_reg};
    assign emag       = sdiff[48] ? 49'(-sdiff) : sdiff;
    assign e20        = ({5'd0, emag} << 4) + ({5'd0, emag} << 2);
    assign pr19       = ({6'd0, pr} << 4) + ({6'd0, pr} << 1) + {6'd0, pr};
    assign stall_skip = (abs48(prev_drive_reg) < thr_reg) || (pr < REF_MIN_Q);

    always_comb
    begin
        if (e20 > pr19)
        begin
            stall_cnt_next = (stall_cnt_reg < STALL_MAX) ? stall_cnt_reg + 10'd1
                                                         : stall_cnt_reg;
        end
        else
        begin
            stall_cnt_next = '0;
        end
    end

    assign clamp_s   = $signed({1'b0, int_clamp_reg});
    assign lim_s     = $signed({1'b0, out_limit_reg});
    assign ti        = sat50(sx50(iacc_reg) + sx50(iterm_reg));
    assign pi        = sat50(sx50(pout_reg) + sx50(iacc_reg));
    assign to        = sat50(sx50(pi) + sx50(dout_reg));
    assign iacc_next = ti;
    assign drv_next  = to;

    always_comb
    begin
        is_call = 1'b1;
        alu_req.op = ALU_MUL;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (state_reg)
            S_STALL_MUL:
            begin
                alu_req.a = {1'b0, out_limit_reg};
                alu_req.b = OUT_FRAC_Q;
            end
            S_P:
            begin
                alu_req.a = gain_p_reg;
                alu_req.b = err_reg;
            end
            S_I1:
            begin
                alu_req.a = gain_i_reg;
                alu_req.b = ie;
            end
            S_I2:
            begin
                alu_req.a = tmp_reg;
                alu_req.b = dt48;
            end
            S_D1:
            begin
                alu_req.a = gain_d_reg;
                alu_req.b = dsrc;
            end
            S_D2:
            begin
                alu_req.op = ALU_DIV;
                alu_req.a  = tmp_reg;
                alu_req.b  = dt48;
            end
            S_VR_DIV:
            begin
                alu_req.op = ALU_DIV;
                alu_req.a  = vr_num;
                alu_req.b  = {1'b0, VAR_RATE_SLOPE};
            end
            S_VR_MUL:
            begin
                alu_req.a = iterm_reg;
                alu_req.b = tmp_reg;
            end
            S_LP_M1:
            begin
                alu_req.a = lp_x;
                alu_req.b = dt48;
            end
            S_LP_D1, S_LP_D2:
            begin
                alu_req.op = ALU_DIV;
                alu_req.a  = tmp_reg;
                alu_req.b  = lp_den;
            end
            S_LP_M2:
            begin
                alu_req.a = lp_last;
                alu_req.b = {1'b0, lp_rc};
            end
            default:
            begin
                is_call = 1'b0;
            end
        endcase
        alu_req.start = is_call && !pend_reg;
    end

    epid_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .done   (alu_done),
        .result (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            out_limit_reg <= '0;
            int_clamp_reg <= '0;
            dead_band_reg <= '0;
            mode_reg <= '0;
            dfilt_rc_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAIN_P:    gain_p_reg    <= cfg_data;
                REG_GAIN_I:    gain_i_reg    <= cfg_data;
                REG_GAIN_D:    gain_d_reg    <= cfg_data;
                REG_OUT_LIMIT: out_limit_reg <= cfg_data[46:0];
                REG_INT_CLAMP: int_clamp_reg <= cfg_data[46:0];
                REG_DEAD_BAND: dead_band_reg <= cfg_data[46:0];
                REG_MODE:      mode_reg      <= cfg_data[6:0];
                REG_DFILT_RC:  dfilt_rc_reg  <= cfg_data[46:0];
                default:       mode_reg      <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            meas_reg <= '0;
            ref_reg <= '0;
            dt_reg <= '0;
            err_reg <= '0;
            pout_reg <= '0;
            iterm_reg <= '0;
            dout_reg <= '0;
            drv_reg <= '0;
            tmp_reg <= '0;
            lpa_reg <= '0;
            lp_sel_reg <= 1'b0;
            thr_reg <= '0;
            pend_reg <= 1'b0;
            prev_measure_reg <= '0;
            prev_setpoint_reg <= '0;
            prev_error_reg <= '0;
            prev_deriv_reg <= '0;
            prev_drive_reg <= '0;
            iacc_reg <= '0;
            run_sum_reg <= '0;
            stall_cnt_reg <= '0;
            stall_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_drive_reg <= '0;
            out_sum_reg <= '0;
            out_stall_reg <= 1'b0;
        end
        else
        begin
            if (alu_req.start)
            begin
                pend_reg <= 1'b1;
            end
            if (alu_done)
            begin
                pend_reg <= 1'b0;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        meas_reg  <= measure;
                        ref_reg   <= setpoint;
                        dt_reg    <= step_time;
                        state_reg <= mode_reg[MODE_STALL] ? S_STALL_MUL : S_ERR;
                    end
                end
                S_STALL_MUL:
                begin
                    if (alu_done)
                    begin
                        thr_reg   <= alu_res;
                        state_reg <= S_STALL_UPD;
                    end
                end
                S_STALL_UPD:
                begin
                    if (!stall_skip)
                    begin
                        stall_cnt_reg <= stall_cnt_next;
                        if (stall_cnt_next > STALL_LIMIT)
                        begin
                            stall_flag_reg <= 1'b1;
                        end
                    end
                    state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    err_reg <= err_c;
                    if (err_abs <= {1'b0, dead_band_reg})
                    begin
                        drv_reg   <= '0;
                        dout_reg  <= prev_deriv_reg;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_P;
                    end
                end
                S_P:
                begin
                    if (alu_done)
                    begin
                        pout_reg  <= alu_res;
                        state_reg <= S_I1;
                    end
                end
                S_I1:
                begin
                    if (alu_done)
                    begin
                        tmp_reg   <= alu_res;
                        state_reg <= S_I2;
                    end
                end
                S_I2:
                begin
                    if (alu_done)
                    begin
                        iterm_reg <= alu_res;
                        if (dt_reg == 32'd0)
                        begin
                            dout_reg  <= '0;
                            state_reg <= S_VR;
                        end
                        else
                        begin
                            state_reg <= S_D1;
                        end
                    end
                end
                S_D1:
                begin
                    if (alu_done)
                    begin
                        tmp_reg   <= alu_res;
                        state_reg <= S_D2;
                    end
                end
                S_D2:
                begin
                    if (alu_done)
                    begin
                        dout_reg  <= alu_res;
                        state_reg <= S_VR;
                    end
                end
                S_VR:
                begin
                    lp_sel_reg <= 1'b0;
                    if (mode_reg[MODE_VAR] && same_sign(err_reg, iacc_reg)
                        && ae > {1'b0, VAR_RATE_FULL} && ae <= vr_top)
                    begin
                        state_reg <= S_VR_DIV;
                    end
                    else
                    begin
                        if (mode_reg[MODE_VAR] && same_sign(err_reg, iacc_reg) && ae > vr_top)
                        begin
                            iacc_reg  <= '0;
                            iterm_reg <= '0;
                        end
                        state_reg <= mode_reg[MODE_DFILT] ? S_LP : S_ICLAMP;
                    end
                end
                S_VR_DIV:
                begin
                    if (alu_done)
                    begin
                        tmp_reg   <= alu_res;
                        state_reg <= S_VR_MUL;
                    end
                end
                S_VR_MUL:
                begin
                    if (alu_done)
                    begin
                        iterm_reg <= alu_res;
                        state_reg <= mode_reg[MODE_DFILT] ? S_LP : S_ICLAMP;
                    end
                end
                S_LP:
                begin
                    if (lp_den == 48'd0)
                    begin
                        state_reg <= lp_sel_reg ? S_OCLAMP : S_ICLAMP;
                    end
                    else
                    begin
                        state_reg <= S_LP_M1;
                    end
                end
                S_LP_M1:
                begin
                    if (alu_done)
                    begin
                        tmp_reg   <= alu_res;
                        state_reg <= S_LP_D1;
                    end
                end
                S_LP_D1:
                begin
                    if (alu_done)
                    begin
                        lpa_reg   <= alu_res;
                        state_reg <= S_LP_M2;
                    end
                end
                S_LP_M2:
                begin
                    if (alu_done)
                    begin
                        tmp_reg   <= alu_res;
                        state_reg <= S_LP_D2;
                    end
                end
                S_LP_D2:
                begin
                    if (alu_done)
                    begin
                        if (lp_sel_reg)
                        begin
                            drv_reg   <= lp_out;
                            state_reg <= S_OCLAMP;
                        end
                        else
                        begin
                            dout_reg  <= lp_out;
                            state_reg <= S_ICLAMP;
                        end
                    end
                end
                S_ICLAMP:
                begin
                    if (mode_reg[MODE_ICLAMP])
                    begin
                        if ((abs48(to) > {1'b0, out_limit_reg} && same_sign(err_reg, iacc_reg))
                            || ti > clamp_s || ti < -clamp_s)
                        begin
                            iterm_reg <= '0;
                        end
                        if (ti > clamp_s)
                        begin
                            iacc_reg <= clamp_s;
                        end
                        else if (ti < -clamp_s)
                        begin
                            iacc_reg <= -clamp_s;
                        end
                    end
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    iacc_reg  <= iacc_next;
                    state_reg <= S_DRV;
                end
                S_DRV:
                begin
                    drv_reg    <= drv_next;
                    lp_sel_reg <= 1'b1;
                    state_reg  <= mode_reg[MODE_OFILT] ? S_LP : S_OCLAMP;
                end
                S_OCLAMP:
                begin
                    if (drv_reg > lim_s)
                    begin
                        drv_reg <= lim_s;
                    end
                    else if (drv_reg < -lim_s)
                    begin
                        drv_reg <= -lim_s;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        prev_measure_reg  <= meas_reg;
                        prev_setpoint_reg <= ref_reg;
                        prev_error_reg    <= err_reg;
                        prev_deriv_reg    <= dout_reg;
                        prev_drive_reg    <= drv_reg;
                        run_sum_reg       <= sat50(sx50(run_sum_reg) + sx50(drv_reg));
                        out_drive_reg     <= drv_reg;
                        out_sum_reg       <= sat50(sx50(run_sum_reg) + sx50(drv_reg));
                        out_stall_reg     <= stall_flag_reg;
                        out_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = out_drive_reg;
    assign drive_sum = out_sum_reg;
    assign stalled   = out_stall_reg;

endmodule

/* src/epid_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enhanced PID shared arithmetic unit
// Iterative Q16.32 multiply (three 48x16 partial products) and restoring
// divide (one quotient bit a cycle), both saturating to 48 bits.
// ----------------------------------------------------------------------------
module epid_alu
(
    input  logic               clk,
    input  logic               rst_n,
    input  epid_pkg::alu_req_t req,
    output logic               done,
    output epid_pkg::q48_t     result
);
    import epid_pkg::*;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_FIN  = 4'b1000
    } alu_state_t;

    localparam logic [6:0] MUL_LAST = 7'd2;
    localparam logic [6:0] DIV_LAST = 7'd79;

    alu_state_t  state_reg;
    alu_op_t     op_reg;
    logic        neg_reg;
    logic [47:0] ma_reg;
    logic [47:0] mb_reg;
    logic [95:0] acc_reg;
    logic [48:0] q_reg;
    logic [47:0] r_reg;
    logic        ovf_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    q48_t        res_reg;

    logic [47:0] a_mag;
    logic [47:0] b_mag;
    logic [15:0] chunk;
    logic [63:0] pp;
    logic [95:0] pp_sh;
    logic [48:0] r_try;
    logic        r_ge;
    logic [47:0] r_new;
    logic [49:0] q_try;
    logic [63:0] mag;
    q48_t        res_next;

    assign a_mag = abs48(req.a);
    assign b_mag = abs48(req.b);
    assign chunk = mb_reg[{cnt_reg[1:0], 4'b0000} +: 16];
    assign pp    = ma_reg * chunk;
    assign pp_sh = {32'd0, pp} << {cnt_reg[1:0], 4'b0000};
    assign r_try = {r_reg, ma_reg[47]};
    assign r_ge  = r_try >= {1'b0, mb_reg};
    assign r_new = r_ge ? 48'(r_try - {1'b0, mb_reg}) : r_try[47:0];
    assign q_try = {q_reg, r_ge};

    always_comb
    begin
        if (op_reg == ALU_MUL)
        begin
            mag = acc_reg[95:32];
        end
        else if (ovf_reg)
        begin
            mag = '1;
        end
        else
        begin
            mag = {15'd0, q_reg};
        end

        if (op_reg == ALU_DIV && mb_reg == 48'd0)
        begin
            res_next = '0;
        end
        else if (neg_reg)
        begin
            res_next = (mag > 64'h8000_0000_0000) ? Q_MIN : 48'(-mag[47:0]);
        end
        else
        begin
            res_next = (mag > 64'h7FFF_FFFF_FFFF) ? Q_MAX : mag[47:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            op_reg    <= ALU_MUL;
            neg_reg   <= 1'b0;
            ma_reg    <= '0;
            mb_reg    <= '0;
            acc_reg   <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg  <= req.op;
                        acc_reg <= '0;
                        q_reg   <= '0;
                        r_reg   <= '0;
                        ovf_reg <= 1'b0;
                        cnt_reg <= '0;
                        ma_reg  <= a_mag;
                        if (req.op == ALU_MUL)
                        begin
                            mb_reg    <= b_mag;
                            neg_reg   <= req.a[47] ^ req.b[47];
                            state_reg <= A_MUL;
                        end
                        else
                        begin
                            mb_reg    <= req.b;
                            neg_reg   <= req.a[47];
                            state_reg <= A_DIV;
                        end
                    end
                end
                A_MUL:
                begin
                    acc_reg <= acc_reg + pp_sh;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == MUL_LAST)
                    begin
                        state_reg <= A_FIN;
                    end
                end
                A_DIV:
                begin
                    ma_reg  <= {ma_reg[46:0], 1'b0};
                    r_reg   <= r_new;
                    q_reg   <= q_try[48:0];
                    ovf_reg <= ovf_reg | (q_try > 50'h1_0000_0000_0000);
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_reg <= A_FIN;
                    end
                end
                A_FIN:
                begin
                    res_reg   <= res_next;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* src/epid_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enhanced PID port checker
// Watches the request channels of the controller unit over time.
// ----------------------------------------------------------------------------
module epid_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input epid_pkg::q48_t drive,
    input epid_pkg::q48_t drive_sum,
    input logic           stalled
);
    import epid_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(drive_sum))
        else $error("output request changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request accepted while busy");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after request");

    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stalled |=> !out_valid || stalled)
        else $error("stall flag dropped");

endmodule

bind enhanced_pid_controller_unit epid_checker u_epid_checker (.*);
